### rtl/ttbm_pkg.sv
// Shared types and constants for the tunnel best-match table.
`default_nettype none

package ttbm_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_SET_UP = 2'd2,
      FUNC_LOOKUP = 2'd3
   } func_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK,
      ST_RWAIT,
      ST_SWEEP,
      ST_DRAIN,
      ST_APPLY,
      ST_DONE
   } state_type;

   // Best score value meaning "no candidate yet"
   localparam logic [3:0] NO_CAND_SCORE = 4'd8;

   // Score bits
   localparam int SCORE_LOCAL_BIT = 0;
   localparam int SCORE_LINK_BIT  = 1;
   localparam int SCORE_TYPE_BIT  = 2;

   // Result of scoring one entry against the query
   typedef struct packed {
      logic       cand;    // entry is live and remote/key match
      logic [2:0] score;   // mismatch bits
      logic       better;  // beats the current best
   } match_type;

endpackage

`default_nettype wire

### rtl/ttbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ttbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/ttbm_match.sv
// Scores one table entry against the query and compares it with the best so far.
`default_nettype none

module ttbm_match
   import ttbm_pkg::*;
#(
   parameter int LINK_W = 16,
   parameter int RANK_W = 4
) (
   input  wire logic              entry_live,
   input  wire logic [31:0]       entry_remote,
   input  wire logic [31:0]       entry_local,
   input  wire logic [31:0]       entry_key,
   input  wire logic [LINK_W-1:0] entry_link,
   input  wire logic              entry_ether,
   input  wire logic [RANK_W-1:0] entry_rank,
   input  wire logic [31:0]       query_remote,
   input  wire logic [31:0]       query_local,
   input  wire logic [31:0]       query_key,
   input  wire logic [LINK_W-1:0] query_link,
   input  wire logic [3:0]        best_score,
   input  wire logic [RANK_W-1:0] best_rank,
   output match_type              result
);

   logic [2:0] score;

   // mismatch bits
   always_comb begin
      score                  = '0;
      score[SCORE_LOCAL_BIT] = (entry_local != query_local);
      score[SCORE_LINK_BIT]  = (entry_link != query_link);
      score[SCORE_TYPE_BIT]  = !entry_ether;
   end

   // lower score wins, ties go to the newer (lower rank) entry
   always_comb begin
      result.cand   = entry_live && (entry_remote == query_remote)
                      && (entry_key == query_key);
      result.score  = score;
      result.better = result.cand
                      && (({1'b0, score} < best_score)
                          || (({1'b0, score} == best_score) && (entry_rank < best_rank)));
   end

endmodule

`default_nettype wire

### rtl/tunnel_table_best_match_core.sv
// Top level of the tunnel match table with best-match lookup.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_ready | func, slot, addresses, key, link, flags
//  rsp_    | out       | rsp_valid/rsp_ready | hit, hit_slot, mismatch_score
//
// Lookup: one entry per cycle through the entry RAM read port and the shared
// scoring unit, then a drain state before the result is loaded.
// Insert/remove of a valid slot: rank read, rank sweep, then commit (entry write for insert);
// insert of a free slot: sweep, then commit; set-up and ignored requests go straight to the result.
// The next request is taken in the cycle after the result is loaded.
// Reset clears the valid and up bits, the sequencer state and the result valid; no clearing pass is needed.
// A finished result sits in the output register; the next request is taken while
// it waits, and that request stalls at its end until the output register frees.
`default_nettype none

module tunnel_table_best_match_core
   import ttbm_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int LINK_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [3:0]  req_slot,
   input  wire logic [31:0] req_remote_addr,
   input  wire logic [31:0] req_local_addr,
   input  wire logic [31:0] req_tunnel_key,
   input  wire logic [15:0] req_link_index,
   input  wire logic        req_up_flag,
   input  wire logic        req_ether_flag,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_hit,
   output logic [3:0]       rsp_hit_slot,
   output logic [2:0]       rsp_mismatch_score
);

   localparam int SW = $clog2(SLOTS);
   localparam int RW = SW;
   localparam int LW = (LINK_BITS < 16) ? LINK_BITS : 16;
   localparam int DW = 96 + LW + 1;
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   state_type state_ff, state_in;

   // request being worked on
   func_type       op_func_ff;
   logic [SW-1:0]  op_slot_ff;
   logic [31:0]    op_remote_ff;
   logic [31:0]    op_local_ff;
   logic [31:0]    op_key_ff;
   logic [LW-1:0]  op_link_ff;
   logic           op_up_ff;
   logic           op_ether_ff;
   logic           has_old_ff;
   logic [RW-1:0]  old_rank_ff;

   // sweep control
   logic [SW-1:0]  cnt_ff;
   logic           proc_ff;
   logic [SW-1:0]  proc_idx_ff;

   // best candidate
   logic [3:0]     best_score_ff;
   logic [SW-1:0]  best_slot_ff;
   logic [RW-1:0]  best_rank_ff;

   // table flags
   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] up_ff;

   // result register
   logic           rsp_valid_ff;
   logic           rsp_hit_ff;
   logic [3:0]     rsp_hit_slot_ff;
   logic [2:0]     rsp_score_ff;

   // decoded request
   func_type       req_op;
   logic [SW-1:0]  req_idx;
   logic           req_in_range;
   logic           accept;
   logic           out_free;

   // RAM ports
   logic           data_wr_en;
   logic [DW-1:0]  data_wr_data;
   logic [DW-1:0]  data_rd_data;
   logic           rank_wr_en;
   logic [SW-1:0]  rank_wr_addr;
   logic [RW-1:0]  rank_wr_data;
   logic [SW-1:0]  rank_rd_addr;
   logic [RW-1:0]  rank_rd_data;

   // unpacked entry
   logic [31:0]    ent_remote;
   logic [31:0]    ent_local;
   logic [31:0]    ent_key;
   logic [LW-1:0]  ent_link;
   logic           ent_ether;
   match_type      match;
   logic           rank_dec;

   assign req_op       = func_type'(req_func);
   assign req_idx      = SW'(req_slot);
   assign req_in_range = (32'(req_slot) < 32'(SLOTS));
   assign accept       = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_hit_slot       = rsp_hit_slot_ff;
   assign rsp_mismatch_score = rsp_score_ff;

   // entry storage: remote, local, key, link, ether
   assign data_wr_data = {op_remote_ff, op_local_ff, op_key_ff, op_link_ff, op_ether_ff};
   assign ent_ether    = data_rd_data[0];
   assign ent_link     = data_rd_data[LW:1];
   assign ent_key      = data_rd_data[LW+32:LW+1];
   assign ent_local    = data_rd_data[LW+64:LW+33];
   assign ent_remote   = data_rd_data[LW+96:LW+65];

   ttbm_ram #(
      .WIDTH (DW),
      .DEPTH (SLOTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (op_slot_ff),
      .wr_data (data_wr_data),
      .rd_addr (cnt_ff),
      .rd_data (data_rd_data)
   );

   ttbm_ram #(
      .WIDTH (RW),
      .DEPTH (SLOTS)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (rank_wr_addr),
      .wr_data (rank_wr_data),
      .rd_addr (rank_rd_addr),
      .rd_data (rank_rd_data)
   );

   // shared scoring unit
   ttbm_match #(
      .LINK_W (LW),
      .RANK_W (RW)
   ) u_match (
      .entry_live   (valid_ff[proc_idx_ff] && up_ff[proc_idx_ff]),
      .entry_remote (ent_remote),
      .entry_local  (ent_local),
      .entry_key    (ent_key),
      .entry_link   (ent_link),
      .entry_ether  (ent_ether),
      .entry_rank   (rank_rd_data),
      .query_remote (op_remote_ff),
      .query_local  (op_local_ff),
      .query_key    (op_key_ff),
      .query_link   (op_link_ff),
      .best_score   (best_score_ff),
      .best_rank    (best_rank_ff),
      .result       (match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_op == FUNC_LOOKUP) begin
                  state_in = ST_SWEEP;
               end else if (!req_in_range || req_op == FUNC_SET_UP) begin
                  state_in = ST_DONE;
               end else if (valid_ff[req_idx]) begin
                  state_in = ST_RANK;
               end else if (req_op == FUNC_INSERT) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RANK:  state_in = ST_RWAIT;
         ST_RWAIT: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = (op_func_ff == FUNC_LOOKUP) ? ST_DONE : ST_APPLY;
         ST_APPLY: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // rank adjust during an insert/remove sweep: close the gap of the old entry
   assign rank_dec = has_old_ff && (rank_rd_data > old_rank_ff);

   // outputs of the sequencer
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      data_wr_en   = (state_ff == ST_APPLY) && (op_func_ff == FUNC_INSERT);
      rank_rd_addr = (state_ff == ST_RANK) ? op_slot_ff : cnt_ff;
      rank_wr_en   = 1'b0;
      rank_wr_addr = proc_idx_ff;
      rank_wr_data = rank_rd_data + RW'(op_func_ff == FUNC_INSERT) - RW'(rank_dec);
      if (data_wr_en) begin
         rank_wr_en   = 1'b1;
         rank_wr_addr = op_slot_ff;
         rank_wr_data = '0;
      end else if (proc_ff && op_func_ff != FUNC_LOOKUP) begin
         rank_wr_en = valid_ff[proc_idx_ff] && (proc_idx_ff != op_slot_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         proc_ff      <= 1'b0;
         valid_ff     <= '0;
         up_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         proc_ff  <= (state_ff == ST_SWEEP);
         // set-up takes effect at accept
         if (accept && req_in_range && req_op == FUNC_SET_UP) begin
            up_ff[req_idx] <= req_up_flag;
         end
         // commit insert or remove
         if (state_ff == ST_APPLY) begin
            valid_ff[op_slot_ff] <= (op_func_ff == FUNC_INSERT);
            up_ff[op_slot_ff]    <= (op_func_ff == FUNC_INSERT) && op_up_ff;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_func_ff    <= req_op;
         op_slot_ff    <= req_idx;
         op_remote_ff  <= req_remote_addr;
         op_local_ff   <= req_local_addr;
         op_key_ff     <= req_tunnel_key;
         op_link_ff    <= req_link_index[LW-1:0];
         op_up_ff      <= req_up_flag;
         op_ether_ff   <= req_ether_flag;
         has_old_ff    <= req_in_range && valid_ff[req_idx];
         cnt_ff        <= '0;
         best_score_ff <= NO_CAND_SCORE;
         best_slot_ff  <= '0;
         best_rank_ff  <= '0;
      end
      if (state_ff == ST_RWAIT) begin
         old_rank_ff <= rank_rd_data;
      end
      if (state_ff == ST_SWEEP) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      proc_idx_ff <= cnt_ff;
      // keep the best lookup candidate
      if (proc_ff && op_func_ff == FUNC_LOOKUP && match.better) begin
         best_score_ff <= {1'b0, match.score};
         best_slot_ff  <= proc_idx_ff;
         best_rank_ff  <= rank_rd_data;
      end
      // load the result
      if (state_ff == ST_DONE && out_free) begin
         if (op_func_ff == FUNC_LOOKUP && best_score_ff < NO_CAND_SCORE) begin
            rsp_hit_ff      <= 1'b1;
            rsp_hit_slot_ff <= 4'(best_slot_ff);
            rsp_score_ff    <= best_score_ff[2:0];
         end else begin
            rsp_hit_ff      <= 1'b0;
            rsp_hit_slot_ff <= '0;
            rsp_score_ff    <= '0;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/ttbm_checker.sv
// Port-level checks for the tunnel match table, bound to the top level.
`default_nettype none

module ttbm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_hit,
   input wire logic [3:0]  rsp_hit_slot,
   input wire logic [2:0]  rsp_mismatch_score
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_hit_slot) && $stable(rsp_mismatch_score))
      else $error("stalled result changed");

   // a miss or non-lookup result carries zero slot and score
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_slot == 4'd0 && rsp_mismatch_score == 3'd0)
      else $error("miss result not cleared");

   // one request at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // no result out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tunnel_table_best_match_core ttbm_checker u_ttbm_checker (.*);

`default_nettype wire
